### design/tecb_pkg.sv
`default_nettype none
package tecb_pkg;
  localparam int TIMER_SLOTS_DEF = 8;
  localparam int COUNTER_SLOTS_DEF = 8;
  localparam int MAX_OUT = 16;
  localparam logic [30:0] PEND_MAX = 31'h7FFF_FFFF;

  localparam logic [3:0] CMD_TICK = 4'd0;
  localparam logic [3:0] CMD_ADD_T = 4'd1;
  localparam logic [3:0] CMD_PAUSE_T = 4'd2;
  localparam logic [3:0] CMD_RESUME_T = 4'd3;
  localparam logic [3:0] CMD_TOGGLE_T = 4'd4;
  localparam logic [3:0] CMD_REMOVE_T = 4'd5;
  localparam logic [3:0] CMD_SETIVL_T = 4'd6;
  localparam logic [3:0] CMD_RESTAMP_T = 4'd7;
  localparam logic [3:0] CMD_CLEAR_T = 4'd8;
  localparam logic [3:0] CMD_ADD_C = 4'd9;
  localparam logic [3:0] CMD_PAUSE_C = 4'd10;
  localparam logic [3:0] CMD_RESUME_C = 4'd11;
  localparam logic [3:0] CMD_REMOVE_C = 4'd12;
  localparam logic [3:0] CMD_READ_C = 4'd13;
  localparam logic [3:0] CMD_CLEAR_C = 4'd14;
  localparam logic [3:0] CMD_POST_C = 4'd15;

  localparam logic [1:0] KIND_RESP = 2'd0;
  localparam logic [1:0] KIND_TIMER = 2'd1;
  localparam logic [1:0] KIND_COUNTER = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [31:0] id;
    logic [1:0] status;
    logic [30:0] pend;
    logic last;
  } result_t;
endpackage
`default_nettype wire

### design/timer_and_event_counter_bank_core.sv
`default_nettype none
// Add and clear go straight to the response; other commands scan the slots in order up
// to the matching id (or past the used slots if it is absent), then respond, and a
// removal first shifts the later slots down. A tick scans the used timer slots, then the
// counter slots, with a compaction after each one-shot that fires, then emits its final
// result; one request is taken at a time, once the last result has left.
// Reset (rst_n low, synchronous): both banks empty, id generator at 1.
module timer_and_event_counter_bank_core #(
  parameter int TIMER_SLOTS = tecb_pkg::TIMER_SLOTS_DEF,
  parameter int COUNTER_SLOTS = tecb_pkg::COUNTER_SLOTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // command[3:0], now_ms[35:4], target_id[67:36], interval_ms[99:68],
  // start_enabled[100], repeat_mode[101], posted_count[117:102], zero fill
  input  wire logic [119:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // event_kind[1:0], item_id[33:2], status[35:34], pending_count[66:36], zero fill
  output logic [71:0]       out_tdata,
  output logic              out_tlast
);
  import tecb_pkg::*;

  localparam int TW = $clog2(TIMER_SLOTS + 1);
  localparam int CW = $clog2(COUNTER_SLOTS + 1);
  localparam int TI = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CI = (COUNTER_SLOTS > 1) ? $clog2(COUNTER_SLOTS) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_TSCAN = 7'b0000010,
    S_TDROP = 7'b0000100,
    S_CSCAN = 7'b0001000,
    S_CDROP = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t state_r;

  logic [31:0] t_id_r [TIMER_SLOTS];
  logic [31:0] t_per_r [TIMER_SLOTS];
  logic [31:0] t_stp_r [TIMER_SLOTS];
  logic        t_act_r [TIMER_SLOTS];
  logic        t_rep_r [TIMER_SLOTS];
  logic [31:0] c_id_r [COUNTER_SLOTS];
  logic [15:0] c_post_r [COUNTER_SLOTS];
  logic [30:0] c_pend_r [COUNTER_SLOTS];
  logic        c_act_r [COUNTER_SLOTS];
  logic [TW-1:0] t_used_r;
  logic [CW-1:0] c_used_r;
  logic [31:0] next_id_r;

  logic [3:0]  cmd_r;
  logic [31:0] now_r, tid_r, ivl_r;
  logic        en_r, rep_r;
  logic [15:0] post_r;
  logic [7:0]  idx_r;       // scan index, wide enough for 64 slots plus one
  logic [7:0]  didx_r;      // compaction index
  logic [4:0]  nout_r;
  logic        tick_r;      // scan belongs to a tick
  logic        found_r;

  result_t res_r;           // pending response / fired result
  logic    res_pend_r;      // fired result waits in res_r to be emitted
  logic    out_v_r;
  result_t out_r;

  logic [TI-1:0] ti;
  logic [CI-1:0] ci;
  assign ti = idx_r[TI-1:0];
  assign ci = idx_r[CI-1:0];

  logic expired, id_hit;
  logic [31:0] sel_id;
  logic t_in, c_in;
  assign t_in = ({24'd0, idx_r} < {{(32-TW){1'b0}}, t_used_r}) && (idx_r < 8'(TIMER_SLOTS));
  assign c_in = ({24'd0, idx_r} < {{(32-CW){1'b0}}, c_used_r}) && (idx_r < 8'(COUNTER_SLOTS));
  assign sel_id = (state_r == S_CSCAN) ? c_id_r[ci] : t_id_r[ti];

  tecb_cmp u_cmp (
    .now_ms (now_r),
    .stamp  (t_stp_r[ti]),
    .period (t_per_r[ti]),
    .id_a   (sel_id),
    .id_b   (tid_r),
    .expired(expired),
    .id_hit (id_hit)
  );

  assign in_tready = (state_r == S_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata = {5'd0, out_r.pend, out_r.status, out_r.id, out_r.kind};
  assign out_tlast = out_r.last;

  logic out_free;
  assign out_free = !out_v_r || out_tready;

  // A new fired result may be taken when the held one can move to the output
  // register, or when nothing is held, or when the result limit is reached.
  logic hold_ok;
  assign hold_ok = (nout_r >= 5'(MAX_OUT)) || !res_pend_r || out_free;

  logic [31:0] psum;
  assign psum = {1'b0, c_pend_r[ci]} + {16'd0, c_post_r[ci]};

  always_ff @(posedge clk) begin
    logic        load;
    logic [30:0] p;
    result_t     rsp;
    load = 1'b0;
    p = '0;
    rsp = res_r;
    if (!rst_n) begin
      state_r <= S_IDLE;
      t_used_r <= '0;
      c_used_r <= '0;
      next_id_r <= 32'd1;
      out_v_r <= 1'b0;
      res_pend_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            cmd_r <= in_tdata[3:0];
            now_r <= in_tdata[35:4];
            tid_r <= in_tdata[67:36];
            ivl_r <= in_tdata[99:68];
            en_r <= in_tdata[100];
            rep_r <= in_tdata[101];
            post_r <= in_tdata[117:102];
            idx_r <= '0;
            nout_r <= '0;
            found_r <= 1'b0;
            tick_r <= (in_tdata[3:0] == CMD_TICK);
            res_r <= '{kind: KIND_RESP, id: in_tdata[67:36], status: ST_OK,
                       pend: '0, last: 1'b1};
            case (in_tdata[3:0])
              CMD_TICK: state_r <= S_TSCAN;
              CMD_ADD_T, CMD_ADD_C, CMD_CLEAR_T, CMD_CLEAR_C: state_r <= S_RESP;
              CMD_PAUSE_T, CMD_RESUME_T, CMD_TOGGLE_T, CMD_REMOVE_T,
              CMD_SETIVL_T, CMD_RESTAMP_T: state_r <= S_TSCAN;
              default: state_r <= S_CSCAN;
            endcase
          end
        end
        S_TSCAN: begin
          if (!t_in) begin
            if (tick_r) begin
              idx_r <= '0;
              state_r <= S_CSCAN;
            end else begin
              res_r.status <= ST_NOT_FOUND;
              state_r <= S_RESP;
            end
          end else if (tick_r) begin
            if (t_act_r[ti] && expired) begin
              // A held result leaves only when a newer one replaces it, so the
              // one still held when the scan ends is the one that carries tlast.
              if (hold_ok) begin
                t_stp_r[ti] <= now_r;
                if (nout_r < 5'(MAX_OUT)) begin
                  if (res_pend_r) begin
                    out_r <= res_r;
                    load = 1'b1;
                  end
                  res_r <= '{kind: KIND_TIMER, id: t_id_r[ti], status: ST_OK,
                             pend: '0, last: 1'b0};
                  res_pend_r <= 1'b1;
                  nout_r <= nout_r + 5'd1;
                end
                if (!t_rep_r[ti]) begin
                  didx_r <= idx_r;
                  state_r <= S_TDROP;
                end else begin
                  idx_r <= idx_r + 8'd1;
                end
              end
            end else begin
              idx_r <= idx_r + 8'd1;
            end
          end else if (id_hit) begin
            case (cmd_r)
              CMD_PAUSE_T: t_act_r[ti] <= 1'b0;
              CMD_RESUME_T: begin
                t_act_r[ti] <= 1'b1;
                t_stp_r[ti] <= now_r;
              end
              CMD_TOGGLE_T: begin
                t_act_r[ti] <= !t_act_r[ti];
                if (!t_act_r[ti]) t_stp_r[ti] <= now_r;
              end
              CMD_SETIVL_T: begin
                t_per_r[ti] <= ivl_r;
                t_stp_r[ti] <= now_r;
              end
              CMD_RESTAMP_T: t_stp_r[ti] <= now_r;
              default: ;
            endcase
            if (cmd_r == CMD_REMOVE_T) begin
              didx_r <= idx_r;
              state_r <= S_TDROP;
            end else begin
              state_r <= S_RESP;
            end
          end else begin
            idx_r <= idx_r + 8'd1;
          end
        end
        S_TDROP: begin
          // Shift one slot down per cycle until the end of the bank.
          if ((didx_r + 8'd1 < {{(8-TW){1'b0}}, t_used_r}) &&
              (didx_r + 8'd1 < 8'(TIMER_SLOTS))) begin
            t_id_r[didx_r[TI-1:0]] <= t_id_r[TI'(didx_r + 8'd1)];
            t_per_r[didx_r[TI-1:0]] <= t_per_r[TI'(didx_r + 8'd1)];
            t_stp_r[didx_r[TI-1:0]] <= t_stp_r[TI'(didx_r + 8'd1)];
            t_act_r[didx_r[TI-1:0]] <= t_act_r[TI'(didx_r + 8'd1)];
            t_rep_r[didx_r[TI-1:0]] <= t_rep_r[TI'(didx_r + 8'd1)];
            didx_r <= didx_r + 8'd1;
          end else begin
            t_used_r <= t_used_r - TW'(1);
            state_r <= tick_r ? S_TSCAN : S_RESP;
          end
        end
        S_CSCAN: begin
          if (!c_in) begin
            if (tick_r) begin
              if (res_pend_r) begin
                res_r.last <= 1'b1;
                state_r <= S_EMIT;
              end else begin
                state_r <= S_IDLE;
              end
            end else begin
              res_r.status <= ST_NOT_FOUND;
              state_r <= S_RESP;
            end
          end else if (tick_r) begin
            if (c_act_r[ci]) begin
              p = c_pend_r[ci];
              if (c_post_r[ci] != 16'd0) p = psum[31] ? PEND_MAX : psum[30:0];
              if ((p == 31'd0) || hold_ok) begin
                if (c_post_r[ci] != 16'd0) c_post_r[ci] <= '0;
                if (p != 31'd0) begin
                  c_pend_r[ci] <= p - 31'd1;
                  if (nout_r < 5'(MAX_OUT)) begin
                    if (res_pend_r) begin
                      out_r <= res_r;
                      load = 1'b1;
                    end
                    res_r <= '{kind: KIND_COUNTER, id: c_id_r[ci], status: ST_OK,
                               pend: '0, last: 1'b0};
                    res_pend_r <= 1'b1;
                    nout_r <= nout_r + 5'd1;
                  end
                end else begin
                  c_pend_r[ci] <= p;
                end
                idx_r <= idx_r + 8'd1;
              end
            end else begin
              idx_r <= idx_r + 8'd1;
            end
          end else if (id_hit) begin
            case (cmd_r)
              CMD_PAUSE_C: c_act_r[ci] <= 1'b0;
              CMD_RESUME_C: c_act_r[ci] <= 1'b1;
              CMD_READ_C: res_r.pend <= c_pend_r[ci];
              CMD_POST_C: c_post_r[ci] <= post_r;
              default: ;
            endcase
            if (cmd_r == CMD_REMOVE_C) begin
              didx_r <= idx_r;
              state_r <= S_CDROP;
            end else begin
              state_r <= S_RESP;
            end
          end else begin
            idx_r <= idx_r + 8'd1;
          end
        end
        S_CDROP: begin
          if ((didx_r + 8'd1 < {{(8-CW){1'b0}}, c_used_r}) &&
              (didx_r + 8'd1 < 8'(COUNTER_SLOTS))) begin
            c_id_r[didx_r[CI-1:0]] <= c_id_r[CI'(didx_r + 8'd1)];
            c_post_r[didx_r[CI-1:0]] <= c_post_r[CI'(didx_r + 8'd1)];
            c_pend_r[didx_r[CI-1:0]] <= c_pend_r[CI'(didx_r + 8'd1)];
            c_act_r[didx_r[CI-1:0]] <= c_act_r[CI'(didx_r + 8'd1)];
            didx_r <= didx_r + 8'd1;
          end else begin
            c_used_r <= c_used_r - CW'(1);
            state_r <= S_RESP;
          end
        end
        S_EMIT: begin
          // The last fired result of the tick, already marked with tlast.
          if (out_free) begin
            out_r <= res_r;
            load = 1'b1;
            res_pend_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        S_RESP: begin
          if (!out_v_r) begin
            if (cmd_r == CMD_ADD_T) begin
              if ({{(32-TW){1'b0}}, t_used_r} >= 32'(TIMER_SLOTS)) begin
                rsp.id = '0;
                rsp.status = ST_FULL;
              end else begin
                rsp.id = next_id_r;
                t_id_r[TI'(t_used_r)] <= next_id_r;
                t_per_r[TI'(t_used_r)] <= ivl_r;
                t_stp_r[TI'(t_used_r)] <= now_r;
                t_act_r[TI'(t_used_r)] <= en_r;
                t_rep_r[TI'(t_used_r)] <= rep_r;
                t_used_r <= t_used_r + TW'(1);
                next_id_r <= (next_id_r == 32'hFFFF_FFFF) ? 32'd1 : next_id_r + 32'd1;
              end
            end else if (cmd_r == CMD_ADD_C) begin
              if ({{(32-CW){1'b0}}, c_used_r} >= 32'(COUNTER_SLOTS)) begin
                rsp.id = '0;
                rsp.status = ST_FULL;
              end else begin
                rsp.id = next_id_r;
                c_id_r[CI'(c_used_r)] <= next_id_r;
                c_post_r[CI'(c_used_r)] <= '0;
                c_pend_r[CI'(c_used_r)] <= '0;
                c_act_r[CI'(c_used_r)] <= en_r;
                c_used_r <= c_used_r + CW'(1);
                next_id_r <= (next_id_r == 32'hFFFF_FFFF) ? 32'd1 : next_id_r + 32'd1;
              end
            end else if (cmd_r == CMD_CLEAR_T) begin
              t_used_r <= '0;
              rsp.id = '0;
            end else if (cmd_r == CMD_CLEAR_C) begin
              c_used_r <= '0;
              rsp.id = '0;
            end
            out_r <= rsp;
            load = 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      out_v_r <= load || (out_v_r && !out_tready);
    end
  end

  // Ids handed out are never zero.
  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r != 32'd0) else $error("id generator reached zero");
  // Bank fill counts never exceed the slot counts.
  a_t_used: assert property (@(posedge clk) disable iff (!rst_n)
    {{(32-TW){1'b0}}, t_used_r} <= 32'(TIMER_SLOTS)) else $error("timer bank overfilled");
  a_c_used: assert property (@(posedge clk) disable iff (!rst_n)
    {{(32-CW){1'b0}}, c_used_r} <= 32'(COUNTER_SLOTS)) else $error("counter bank overfilled");
  // No request is taken while a scan is running.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("ready while busy");
  // Result count per tick stays within the limit.
  a_nout: assert property (@(posedge clk) disable iff (!rst_n)
    nout_r <= 5'(MAX_OUT)) else $error("too many results");
endmodule
`default_nettype wire

### design/tecb_cmp.sv
`default_nettype none
// Shared compare unit: wrap-safe elapsed-time test and id match for one slot.
module tecb_cmp (
  input  wire logic [31:0] now_ms,
  input  wire logic [31:0] stamp,
  input  wire logic [31:0] period,
  input  wire logic [31:0] id_a,
  input  wire logic [31:0] id_b,
  output logic             expired,
  output logic             id_hit
);
  logic [31:0] elapsed;
  assign elapsed = now_ms - stamp;
  assign expired = (elapsed >= period);
  assign id_hit = (id_a == id_b);
endmodule
`default_nettype wire

### sim/timer_bank_monitor.sv
module timer_bank_monitor
  import tecb_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [119:0] in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [71:0]  out_tdata,
  input  wire logic         out_tlast,
  output int                fail_count,
  output int                waiting
);
  localparam int NT = TIMER_SLOTS_DEF;
  localparam int NC = COUNTER_SLOTS_DEF;

  // Shadow copy of both banks and the id generator.
  logic [31:0] tmr_id[NT];
  logic [31:0] tmr_period[NT];
  logic [31:0] tmr_stamp[NT];
  bit          tmr_on[NT];
  bit          tmr_rep[NT];
  int          tmr_count;
  logic [31:0] cnt_id[NC];
  logic [15:0] cnt_posted[NC];
  logic [30:0] cnt_pend[NC];
  bit          cnt_on[NC];
  int          cnt_count;
  logic [31:0] id_gen;

  result_t expected_q[$];

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("mismatch %s: expected %0h, got %0h", what, want, got);
    fail_count++;
  endtask

  task automatic push(input logic [1:0] kind, input logic [31:0] id, input logic [1:0] st,
                      input logic [30:0] pend);
    result_t r;
    r.kind = kind;
    r.id = id;
    r.status = st;
    r.pend = pend;
    r.last = 1'b0;
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic drop_tmr(input int k);
    for (int i = k; i + 1 < tmr_count; i++) begin
      tmr_id[i] = tmr_id[i+1];
      tmr_period[i] = tmr_period[i+1];
      tmr_stamp[i] = tmr_stamp[i+1];
      tmr_on[i] = tmr_on[i+1];
      tmr_rep[i] = tmr_rep[i+1];
    end
    tmr_count--;
  endtask

  task automatic drop_cnt(input int k);
    for (int i = k; i + 1 < cnt_count; i++) begin
      cnt_id[i] = cnt_id[i+1];
      cnt_posted[i] = cnt_posted[i+1];
      cnt_pend[i] = cnt_pend[i+1];
      cnt_on[i] = cnt_on[i+1];
    end
    cnt_count--;
  endtask

  task automatic predict_request(input logic [119:0] d);
    logic [3:0]  cmd;
    logic [31:0] now, tid, ivl, age, id;
    logic [15:0] post;
    logic [31:0] sum;
    logic [1:0]  st;
    logic [30:0] pend;
    bit          en, rep;
    int          i, k, fired;
    cmd = d[3:0];
    now = d[35:4];
    tid = d[67:36];
    ivl = d[99:68];
    en = d[100];
    rep = d[101];
    post = d[117:102];
    id = tid;
    st = ST_OK;
    pend = '0;
    k = -1;
    fired = 0;
    if (cmd == CMD_TICK) begin
      i = 0;
      while (i < tmr_count) begin
        age = now - tmr_stamp[i];
        if (tmr_on[i] && age >= tmr_period[i]) begin
          tmr_stamp[i] = now;
          if (fired < MAX_OUT) begin
            push(KIND_TIMER, tmr_id[i], ST_OK, '0);
            fired++;
          end
          if (!tmr_rep[i]) begin
            drop_tmr(i);
            continue;
          end
        end
        i++;
      end
      for (i = 0; i < cnt_count; i++) begin
        if (!cnt_on[i]) continue;
        if (cnt_posted[i] != 0) begin
          sum = {1'b0, cnt_pend[i]} + cnt_posted[i];
          cnt_pend[i] = (sum > {1'b0, PEND_MAX}) ? PEND_MAX : sum[30:0];
          cnt_posted[i] = '0;
        end
        if (cnt_pend[i] != 0) begin
          cnt_pend[i]--;
          if (fired < MAX_OUT) begin
            push(KIND_COUNTER, cnt_id[i], ST_OK, '0);
            fired++;
          end
        end
      end
      // A tick that fires nothing produces no result at all.
      if (fired > 0) expected_q[$].last = 1'b1;
      return;
    end
    if (cmd == CMD_ADD_T || cmd == CMD_ADD_C) begin
      if ((cmd == CMD_ADD_T && tmr_count >= NT) || (cmd == CMD_ADD_C && cnt_count >= NC)) begin
        id = '0;
        st = ST_FULL;
      end else begin
        id = id_gen;
        id_gen = (id_gen == 32'hFFFF_FFFF) ? 32'd1 : id_gen + 1;
        if (cmd == CMD_ADD_T) begin
          tmr_id[tmr_count] = id;
          tmr_period[tmr_count] = ivl;
          tmr_stamp[tmr_count] = now;
          tmr_on[tmr_count] = en;
          tmr_rep[tmr_count] = rep;
          tmr_count++;
        end else begin
          cnt_id[cnt_count] = id;
          cnt_posted[cnt_count] = '0;
          cnt_pend[cnt_count] = '0;
          cnt_on[cnt_count] = en;
          cnt_count++;
        end
      end
    end else if (cmd == CMD_CLEAR_T) begin
      tmr_count = 0;
      id = '0;
    end else if (cmd == CMD_CLEAR_C) begin
      cnt_count = 0;
      id = '0;
    end else if (cmd >= CMD_PAUSE_T && cmd <= CMD_RESTAMP_T) begin
      for (i = 0; i < tmr_count; i++)
        if (k < 0 && tmr_id[i] == tid) k = i;
      if (k < 0) st = ST_NOT_FOUND;
      else case (cmd)
        CMD_PAUSE_T: tmr_on[k] = 1'b0;
        CMD_RESUME_T: begin
          tmr_on[k] = 1'b1;
          tmr_stamp[k] = now;
        end
        CMD_TOGGLE_T: begin
          tmr_on[k] = !tmr_on[k];
          if (tmr_on[k]) tmr_stamp[k] = now;
        end
        CMD_REMOVE_T: drop_tmr(k);
        CMD_SETIVL_T: begin
          tmr_period[k] = ivl;
          tmr_stamp[k] = now;
        end
        default: tmr_stamp[k] = now;
      endcase
    end else begin
      for (i = 0; i < cnt_count; i++)
        if (k < 0 && cnt_id[i] == tid) k = i;
      if (k < 0) st = ST_NOT_FOUND;
      else case (cmd)
        CMD_PAUSE_C: cnt_on[k] = 1'b0;
        CMD_RESUME_C: cnt_on[k] = 1'b1;
        CMD_REMOVE_C: drop_cnt(k);
        CMD_READ_C: pend = cnt_pend[k];
        default: cnt_posted[k] = post;
      endcase
    end
    push(KIND_RESP, id, st, pend);
    expected_q[$].last = 1'b1;
  endtask

  initial begin
    fail_count = 0;
    waiting = 0;
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      tmr_count = 0;
      cnt_count = 0;
      id_gen = 32'd1;
      expected_q.delete();
    end else begin
      // Results are checked before the new request is predicted, so a result
      // can never be matched against an expectation from the same edge.
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("unexpected result: tdata %0h last %0b", out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[1:0] != want.kind) report("event_kind", want.kind, out_tdata[1:0]);
          if (out_tdata[33:2] != want.id) report("item_id", want.id, out_tdata[33:2]);
          if (out_tdata[35:34] != want.status)
            report("status", want.status, out_tdata[35:34]);
          if (out_tdata[66:36] != want.pend)
            report("pending_count", want.pend, out_tdata[66:36]);
          if (out_tdata[71:67] != '0) report("zero fill", 0, out_tdata[71:67]);
          if (out_tlast != want.last) report("last_of_run", want.last, out_tlast);
        end
      end
      if (in_tvalid && in_tready) predict_request(in_tdata);
    end
    waiting = expected_q.size();
  end

  final begin
    if (expected_q.size() != 0) $display("%0d results never arrived", expected_q.size());
  end
endmodule

### sim/timer_and_event_counter_bank_core_test.sv
module timer_and_event_counter_bank_core_test;
  import tecb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;
  logic         out_tlast;
  int           fail_count;
  int           waiting;

  bit          no_gaps = 1'b0;
  bit          rx_hold = 1'b0;
  int          rx_gap = 0;
  int          cycles = 0;
  logic [31:0] clock_ms = 32'd100;
  logic [31:0] ids_issued = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timer_and_event_counter_bank_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  timer_bank_monitor monitor (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .fail_count(fail_count), .waiting(waiting)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: a random stall after each accepted result, plus one long hold.
  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold) begin
      out_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      out_tready <= 1'b0;
    end else if (out_tready && out_tvalid) begin
      g = no_gaps ? 0 : $urandom_range(0, 8);
      out_tready <= (g == 0);
      rx_gap <= (g == 0) ? 0 : g - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    wait (rst_n);
    repeat (1500) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send(input logic [3:0] cmd, input logic [31:0] now, input logic [31:0] tid,
                      input logic [31:0] ivl, input bit en, input bit rep,
                      input logic [15:0] post);
    int g;
    g = no_gaps ? 0 : $urandom_range(0, 8);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, post, rep, en, ivl, tid, now, cmd};
    if (cmd == CMD_ADD_T || cmd == CMD_ADD_C) ids_issued = ids_issued + 1;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] pick_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'd0;
    if (r < 12) return $urandom();
    if (ids_issued < 10) return $urandom_range(1, 10);
    return $urandom_range(ids_issued - 9, ids_issued + 1);
  endfunction

  initial begin
    int r;
    logic [3:0] cmd;
    logic [31:0] ivl;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: extremes, full banks, unknown ids and a quiet tick.
    send(CMD_TICK, 32'd0, 0, 0, 1, 1, 0);
    send(CMD_ADD_T, 32'hFFFF_FFF0, 0, 32'd0, 1, 1, 0);
    send(CMD_ADD_T, 32'hFFFF_FFF0, 0, 32'hFFFF_FFFF, 1, 1, 0);
    send(CMD_ADD_T, 32'hFFFF_FFF0, 0, 32'd20, 1, 0, 0);
    send(CMD_ADD_T, 32'hFFFF_FFF0, 0, 32'd5, 0, 1, 0);
    send(CMD_TICK, 32'h0000_0008, 0, 0, 0, 0, 0);
    send(CMD_TICK, 32'h0000_0010, 0, 0, 0, 0, 0);
    send(CMD_PAUSE_T, 32'd20, 1, 0, 0, 0, 0);
    send(CMD_RESUME_T, 32'd21, 1, 0, 0, 0, 0);
    send(CMD_TOGGLE_T, 32'd22, 4, 0, 0, 0, 0);
    send(CMD_SETIVL_T, 32'd23, 2, 32'd3, 0, 0, 0);
    send(CMD_RESTAMP_T, 32'd24, 1, 0, 0, 0, 0);
    send(CMD_REMOVE_T, 32'd25, 32'd0, 0, 0, 0, 0);
    send(CMD_REMOVE_T, 32'd25, 32'hFFFF_FFFF, 0, 0, 0, 0);
    for (int i = 0; i < 9; i++) send(CMD_ADD_C, 32'd30, 0, 0, i != 3, 0, 0);
    send(CMD_POST_C, 32'd31, 6, 0, 0, 0, 16'hFFFF);
    send(CMD_POST_C, 32'd31, 8, 0, 0, 0, 16'd2);
    send(CMD_TICK, 32'd40, 0, 0, 0, 0, 0);
    send(CMD_READ_C, 32'd41, 6, 0, 0, 0, 0);
    for (int i = 0; i < 6; i++) send(CMD_ADD_T, 32'd50, 0, 32'd0, 1, i[0], 0);
    send(CMD_TICK, 32'd60, 0, 0, 0, 0, 0);
    send(CMD_RESUME_C, 32'd61, 8, 0, 0, 0, 0);
    send(CMD_PAUSE_C, 32'd61, 7, 0, 0, 0, 0);
    send(CMD_REMOVE_C, 32'd62, 9, 0, 0, 0, 0);
    send(CMD_CLEAR_T, 32'd63, 0, 0, 0, 0, 0);
    send(CMD_CLEAR_C, 32'd63, 0, 0, 0, 0, 0);

    for (int n = 0; n < 360; n++) begin
      if (n % 60 == 0) no_gaps = (n / 60) % 3 == 1;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 40) == 0) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(0, 30);
      ivl = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 60);
      if (r < 28) cmd = CMD_TICK;
      else if (r < 40) cmd = CMD_ADD_T;
      else if (r < 50) cmd = CMD_ADD_C;
      else if (r < 62) cmd = CMD_POST_C;
      else if (r < 65) cmd = ($urandom_range(0, 1) != 0) ? CMD_CLEAR_T : CMD_CLEAR_C;
      else cmd = 4'($urandom_range(CMD_PAUSE_T, CMD_RESTAMP_T) + (r < 82 ? 0 : 8));
      send(cmd, clock_ms, pick_target(), ivl, $urandom_range(0, 4) != 0,
           $urandom_range(0, 2) != 0, 16'(($urandom_range(0, 3) == 0) ? $urandom() :
           $urandom_range(0, 4)));
    end
    @(posedge clk);
    in_tvalid <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
